[sv/tac_pkg.sv]
package tac_pkg;

  localparam int NUM_AXES      = 6;
  localparam int NUM_THRUSTERS = 8;
  localparam int NUM_RESULTS   = NUM_AXES + NUM_THRUSTERS;
  localparam int POS_W         = $clog2(NUM_RESULTS);

  // pipeline depth from tick acceptance to settled thrusts
  localparam int CALC_LAT = 5;
  localparam int CNT_W    = $clog2(CALC_LAT + 1);

  localparam int DEADBAND_Q15 = 3276;

  typedef logic signed [15:0] axis_t;
  typedef logic        [15:0] gain_t;
  typedef logic signed [17:0] amount_t;
  typedef logic signed [15:0] coef_t;

  typedef axis_t   [NUM_AXES-1:0]      cmd_vec_t;
  typedef gain_t   [NUM_AXES-1:0]      gain_vec_t;
  typedef amount_t [NUM_AXES-1:0]      force_vec_t;
  typedef amount_t [NUM_THRUSTERS-1:0] thrust_vec_t;

  // input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // result kinds
  localparam logic KIND_FORCE  = 1'b0;
  localparam logic KIND_THRUST = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SURGE_GAIN,
    REG_SWAY_GAIN,
    REG_HEAVE_GAIN,
    REG_ROLL_GAIN,
    REG_PITCH_GAIN,
    REG_YAW_GAIN,
    REG_HORIZONTAL_LIMIT,
    REG_VERTICAL_LIMIT
  } reg_idx_t;

  localparam gain_vec_t GAIN_RESET = {16'd3840, 16'd1280, 16'd1280,
                                      16'd3840, 16'd5120, 16'd5120};
  localparam gain_t HLIM_RESET = 16'd4352;
  localparam gain_t VLIM_RESET = 16'd12800;

  // pseudo-inverse allocation matrix, Q2.14, row per thruster
  localparam coef_t ALLOC_COEF [NUM_THRUSTERS][NUM_AXES] = '{
    '{16'sd5793, -16'sd5793, 16'sd0,    16'sd0,      16'sd0,      -16'sd5793},
    '{16'sd5793,  16'sd5793, 16'sd0,    16'sd0,      16'sd0,      -16'sd5793},
    '{16'sd5793, -16'sd5793, 16'sd0,    16'sd0,      16'sd0,       16'sd5793},
    '{16'sd5793,  16'sd5793, 16'sd0,    16'sd0,      16'sd0,       16'sd5793},
    '{16'sd0,     16'sd0,    16'sd4096, 16'sd16384, -16'sd16384,   16'sd0},
    '{16'sd0,     16'sd0,    16'sd4096, 16'sd16384,  16'sd16384,   16'sd0},
    '{16'sd0,     16'sd0,    16'sd4096, -16'sd16384, 16'sd16384,   16'sd0},
    '{16'sd0,     16'sd0,    16'sd4096, -16'sd16384, -16'sd16384,  16'sd0}
  };

  // zero inside the +-0.1 band
  function automatic axis_t deadband(input axis_t x);
    axis_t r;
    r = x;
    if ((x <= 16'sd3276) && (x >= -16'sd3276)) begin
      r = '0;
    end
    return r;
  endfunction

  // negation that saturates the most negative code
  function automatic axis_t negate_sat(input axis_t x);
    axis_t r;
    r = -x;
    if (x == -16'sd32768) begin
      r = 16'sd32767;
    end
    return r;
  endfunction

  // saturate to the 18-bit amount range
  function automatic amount_t sat_amount(input logic signed [22:0] v);
    amount_t r;
    r = v[17:0];
    if (v > 23'sd131071) begin
      r = 18'sd131071;
    end else if (v < -23'sd131072) begin
      r = -18'sd131072;
    end
    return r;
  endfunction

endpackage

[sv/thruster_allocation_core.sv]
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | operation, six Q1.15 axes
// out     | out | out_valid/out_ready | kind, channel, amount, last
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a joystick sample is registered on acceptance; a tick runs the lane pipeline
// (force lane two stages, thrust lane three) and then 14 output transactions
// from the single result port, one per cycle when out_ready stays high.
// in_ready is low from a tick until its last result is taken and the sequencer is back in idle.
// synchronous active-low reset restores the gains, limits and held commands;
// cfg_ready is always high.
module thruster_allocation_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_operation,
  input  tac_pkg::axis_t   in_surge_axis,
  input  tac_pkg::axis_t   in_sway_axis,
  input  tac_pkg::axis_t   in_heave_axis,
  input  tac_pkg::axis_t   in_roll_axis,
  input  tac_pkg::axis_t   in_pitch_axis,
  input  tac_pkg::axis_t   in_yaw_axis,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [2:0]       out_channel,
  output tac_pkg::amount_t out_amount,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import tac_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DRAIN} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              load_r;
  gain_vec_t         gain_r;
  gain_t             hlim_r;
  gain_t             vlim_r;
  cmd_vec_t          cmd_r;
  force_vec_t        force_w;
  thrust_vec_t       thrust_w;
  logic              in_take;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      hlim_r <= HLIM_RESET;
      vlim_r <= VLIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HORIZONTAL_LIMIT: hlim_r <= cfg_data;
        REG_VERTICAL_LIMIT:   vlim_r <= cfg_data;
        default:              gain_r[cfg_index] <= cfg_data;
      endcase
    end
  end

  // held commands after deadband, roll negated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else if (in_take && (in_operation == OP_SAMPLE)) begin
      cmd_r[0] <= deadband(in_surge_axis);
      cmd_r[1] <= deadband(in_sway_axis);
      cmd_r[2] <= deadband(in_heave_axis);
      cmd_r[3] <= negate_sat(deadband(in_roll_axis));
      cmd_r[4] <= deadband(in_pitch_axis);
      cmd_r[5] <= deadband(in_yaw_axis);
    end
  end

  // tick sequencing: wait for the lanes, load the merge, drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      load_r  <= 1'b0;
    end else begin
      load_r <= (state_r == ST_CALC) && (cnt_r == CNT_W'(CALC_LAT - 1));
      case (state_r)
        ST_IDLE: begin
          if (in_take && (in_operation == OP_TICK)) begin
            state_r <= ST_CALC;
            cnt_r   <= '0;
          end
        end
        ST_CALC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(CALC_LAT - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!load_r && !out_valid) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // force lanes, one per axis
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_force
    tac_force_lane u_force (
      .clk     (clk),
      .gain_i  (gain_r[a]),
      .cmd_i   (cmd_r[a]),
      .force_o (force_w[a])
    );
  end

  // thrust lanes, one per thruster
  for (genvar t = 0; t < NUM_THRUSTERS; t++) begin : g_thrust
    tac_thrust_lane u_thrust (
      .clk      (clk),
      .thr_i    (3'(t)),
      .force_i  (force_w),
      .limit_i  ((t < NUM_THRUSTERS / 2) ? hlim_r : vlim_r),
      .thrust_o (thrust_w[t])
    );
  end

  // merge stage serialises the fourteen results
  tac_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load_r),
    .force_i     (force_w),
    .thrust_i    (thrust_w),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_channel (out_channel),
    .out_amount  (out_amount),
    .out_last    (out_last)
  );

endmodule

[sv/tac_force_lane.sv]
module tac_force_lane (
  input  logic            clk,
  input  tac_pkg::gain_t  gain_i,
  input  tac_pkg::axis_t  cmd_i,
  output tac_pkg::amount_t force_o
);
  import tac_pkg::*;

  logic signed [32:0] prod_r;
  logic signed [33:0] rnd;
  logic signed [18:0] quo;
  amount_t            force_r;

  // round half up, then floor by 2^15
  always_comb begin
    rnd = {prod_r[32], prod_r} + 34'sd16384;
    quo = rnd[33:15];
  end

  // gain times command, then round and saturate
  always_ff @(posedge clk) begin
    prod_r  <= $signed({1'b0, gain_i}) * cmd_i;
    force_r <= sat_amount({{4{quo[18]}}, quo});
  end

  assign force_o = force_r;

endmodule

[sv/tac_thrust_lane.sv]
module tac_thrust_lane (
  input  logic                clk,
  input  logic [2:0]          thr_i,
  input  tac_pkg::force_vec_t force_i,
  input  tac_pkg::gain_t      limit_i,
  output tac_pkg::amount_t    thrust_o
);
  import tac_pkg::*;

  logic signed [33:0] prod_r [NUM_AXES];
  logic signed [36:0] sum_r;
  logic signed [36:0] sum_nxt;
  logic signed [36:0] rnd;
  logic signed [22:0] quo;
  amount_t            sat18;
  logic signed [18:0] sat19;
  logic signed [18:0] lim19;
  amount_t            thrust_nxt;
  amount_t            thrust_r;

  // one product per axis
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_AXES; j++) begin
      prod_r[j] <= ALLOC_COEF[thr_i][j] * $signed(force_i[j]);
    end
  end

  // sum of the six products
  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < NUM_AXES; j++) begin
      sum_nxt = sum_nxt + {{3{prod_r[j][33]}}, prod_r[j]};
    end
  end

  // round, saturate, then clamp to the symmetric limit
  always_comb begin
    rnd   = sum_r + 37'sd8192;
    quo   = rnd[36:14];
    sat18 = sat_amount(quo);
    sat19 = {sat18[17], sat18};
    lim19 = $signed({3'b000, limit_i});
    if (sat19 >= lim19) begin
      thrust_nxt = lim19[17:0];
    end else if (sat19 <= -lim19) begin
      thrust_nxt = 18'(-lim19);
    end else begin
      thrust_nxt = sat19[17:0];
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    thrust_r <= thrust_nxt;
  end

  assign thrust_o = thrust_r;

endmodule

[sv/tac_merge.sv]
module tac_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  tac_pkg::force_vec_t  force_i,
  input  tac_pkg::thrust_vec_t thrust_i,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [2:0]           out_channel,
  output tac_pkg::amount_t     out_amount,
  output logic                 out_last
);
  import tac_pkg::*;

  amount_t            amt_r [NUM_RESULTS];
  logic [POS_W-1:0]   pos_r;
  logic               valid_r;
  logic               take;

  assign take = valid_r && out_ready;

  // result line: forces first, then thrusts, shifted out at the head
  always_ff @(posedge clk) begin
    if (load_i) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        amt_r[i] <= force_i[i];
      end
      for (int i = 0; i < NUM_THRUSTERS; i++) begin
        amt_r[NUM_AXES + i] <= thrust_i[i];
      end
    end else if (take) begin
      for (int i = 0; i < NUM_RESULTS - 1; i++) begin
        amt_r[i] <= amt_r[i + 1];
      end
    end
  end

  // position and valid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else if (load_i) begin
      pos_r   <= '0;
      valid_r <= 1'b1;
    end else if (take) begin
      pos_r <= pos_r + 1'b1;
      if (pos_r == POS_W'(NUM_RESULTS - 1)) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result labels follow from the position
  always_comb begin
    if (pos_r < POS_W'(NUM_AXES)) begin
      out_kind    = KIND_FORCE;
      out_channel = pos_r[2:0];
    end else begin
      out_kind    = KIND_THRUST;
      out_channel = 3'(pos_r - POS_W'(NUM_AXES));
    end
  end

  assign out_valid  = valid_r;
  assign out_amount = amt_r[0];
  assign out_last   = (pos_r == POS_W'(NUM_RESULTS - 1));

endmodule

[sv/tac_checker.sv]
module tac_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_operation,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_kind,
  input logic [2:0]       out_channel,
  input tac_pkg::amount_t out_amount,
  input logic             out_last
);
  import tac_pkg::*;

  // no new item while results are pending
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  // a tick closes the input
  a_tick_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == OP_TICK)) |=> !in_ready)
    else $error("input still ready after tick");

  // last only on the final thrust
  a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> ((out_kind == KIND_THRUST) && (out_channel == 3'd7)))
    else $error("last on wrong result");

  // nothing follows the last result
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result after last transaction");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_amount)
      && $stable(out_channel) && $stable(out_kind)))
    else $error("stalled result changed");

endmodule

bind thruster_allocation_core tac_checker u_tac_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_kind     (out_kind),
  .out_channel  (out_channel),
  .out_amount   (out_amount),
  .out_last     (out_last)
);

[tb/thruster_allocation_scoreboard.sv]
package thruster_allocation_tb_pkg;

  import tac_pkg::*;

  // axis order of the command vector, also the gain register order
  typedef enum int {
    AX_SURGE,
    AX_SWAY,
    AX_HEAVE,
    AX_ROLL,
    AX_PITCH,
    AX_YAW
  } axis_idx_t;

  typedef struct {
    logic       kind;
    logic [2:0] channel;
    amount_t    amount;
    logic       last;
  } alloc_result_t;

  class allocation_scoreboard;

    axis_t         held_cmd [NUM_AXES];
    gain_t         axis_gain [NUM_AXES];
    gain_t         horiz_lim;
    gain_t         vert_lim;
    alloc_result_t expected_q [$];
    int            errors;

    function new();
      for (int a = 0; a < NUM_AXES; a++) begin
        held_cmd[a]  = '0;
        axis_gain[a] = GAIN_RESET[a];
      end
      horiz_lim = HLIM_RESET;
      vert_lim  = VLIM_RESET;
      errors    = 0;
    endfunction

    // saturate to the 18-bit amount range
    function longint clip_amount(longint v);
      if (v > 131071) begin
        return 131071;
      end else if (v < -131072) begin
        return -131072;
      end
      return v;
    endfunction

    function void write_reg(reg_idx_t idx, gain_t data);
      case (idx)
        REG_HORIZONTAL_LIMIT: horiz_lim = data;
        REG_VERTICAL_LIMIT:   vert_lim  = data;
        default:              axis_gain[int'(idx)] = data;
      endcase
    endfunction

    // accepted input transaction: hold a sample or queue the tick's results
    function void note_input(logic op, cmd_vec_t ax);
      longint        x;
      longint        acc;
      longint        lim;
      longint        thr;
      longint        force_q8 [NUM_AXES];
      alloc_result_t r;
      if (op == OP_SAMPLE) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          x = longint'($signed(ax[a]));
          if (x <= DEADBAND_Q15 && x >= -DEADBAND_Q15) begin
            x = 0;
          end
          // roll is mirrored, the most negative code saturates
          if (a == AX_ROLL) begin
            x = -x;
            if (x > 32767) begin
              x = 32767;
            end
          end
          held_cmd[a] = axis_t'(x);
        end
        return;
      end
      // forces: gain times command, round half up
      for (int a = 0; a < NUM_AXES; a++) begin
        force_q8[a] = clip_amount((longint'(axis_gain[a]) * longint'(held_cmd[a]) + 16384)
                                  >>> 15);
        r.kind    = KIND_FORCE;
        r.channel = 3'(a);
        r.amount  = amount_t'(force_q8[a]);
        r.last    = 1'b0;
        expected_q.push_back(r);
      end
      // thrusts: allocation matrix, saturate, then group limit
      for (int t = 0; t < NUM_THRUSTERS; t++) begin
        acc = 0;
        for (int a = 0; a < NUM_AXES; a++) begin
          acc += longint'(ALLOC_COEF[t][a]) * force_q8[a];
        end
        thr = clip_amount((acc + 8192) >>> 14);
        lim = (t < 4) ? longint'(horiz_lim) : longint'(vert_lim);
        if (thr > lim) begin
          thr = lim;
        end else if (thr < -lim) begin
          thr = -lim;
        end
        r.kind    = KIND_THRUST;
        r.channel = 3'(t);
        r.amount  = amount_t'(thr);
        r.last    = (t == NUM_THRUSTERS - 1);
        expected_q.push_back(r);
      end
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_result(logic kind, logic [2:0] channel, amount_t amount, logic last);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d channel %0d amount %0d last %0d",
               kind, channel, amount, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (channel !== e.channel) begin
        $error("channel: expected %0d, actual %0d", e.channel, channel);
        errors++;
      end
      if (amount !== e.amount) begin
        $error("amount: expected %0d, actual %0d (channel %0d)", e.amount, amount, e.channel);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

  endclass

endpackage

[tb/thruster_allocation_core_tb.sv]
module thruster_allocation_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tac_pkg::*;
  import thruster_allocation_tb_pkg::*;

  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int LONG_HOLD       = 400;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  axis_t      in_surge_axis;
  axis_t      in_sway_axis;
  axis_t      in_heave_axis;
  axis_t      in_roll_axis;
  axis_t      in_pitch_axis;
  axis_t      in_yaw_axis;
  logic       out_valid;
  logic       out_ready;
  logic       out_kind;
  logic [2:0] out_channel;
  amount_t    out_amount;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_rx   = 1'b0;

  allocation_scoreboard alloc_sb;

  thruster_allocation_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_surge_axis(in_surge_axis),
    .in_sway_axis (in_sway_axis),
    .in_heave_axis(in_heave_axis),
    .in_roll_axis (in_roll_axis),
    .in_pitch_axis(in_pitch_axis),
    .in_yaw_axis  (in_yaw_axis),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_channel  (out_channel),
    .out_amount   (out_amount),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // pack six axes, surge in the lowest slot
  function automatic cmd_vec_t mk_axes(int surge, int sway, int heave,
                                       int roll, int pitch, int yaw);
    cmd_vec_t v;
    v[AX_SURGE] = axis_t'(surge);
    v[AX_SWAY]  = axis_t'(sway);
    v[AX_HEAVE] = axis_t'(heave);
    v[AX_ROLL]  = axis_t'(roll);
    v[AX_PITCH] = axis_t'(pitch);
    v[AX_YAW]   = axis_t'(yaw);
    return v;
  endfunction

  // axis value, weighted towards the band edges and the extremes
  function automatic axis_t rand_axis();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return axis_t'($urandom_range(3270, 3283));
      1:       return -axis_t'($urandom_range(3270, 3283));
      2:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      3:       return axis_t'($urandom_range(0, 3276)) - 16'sd1638;
      default: return axis_t'($urandom());
    endcase
  endfunction

  function automatic cmd_vec_t rand_axes();
    cmd_vec_t v;
    for (int a = 0; a < NUM_AXES; a++) begin
      v[a] = rand_axis();
    end
    return v;
  endfunction

  // register value: zero, full scale, small or anything
  function automatic gain_t rand_reg();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 16'd0;
      1:       return 16'hffff;
      2, 3:    return gain_t'($urandom_range(0, 4096));
      default: return gain_t'($urandom());
    endcase
  endfunction

  // one input transaction; valid stays high afterwards
  task automatic send_item(logic op, cmd_vec_t ax);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_surge_axis <= ax[AX_SURGE];
    in_sway_axis  <= ax[AX_SWAY];
    in_heave_axis <= ax[AX_HEAVE];
    in_roll_axis  <= ax[AX_ROLL];
    in_pitch_axis <= ax[AX_PITCH];
    in_yaw_axis   <= ax[AX_YAW];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    alloc_sb.note_input(op, ax);
  endtask

  task automatic send_sample(cmd_vec_t ax);
    send_item(OP_SAMPLE, ax);
  endtask

  // tick carries random axes, they must be ignored
  task automatic send_tick();
    send_item(OP_TICK, rand_axes());
  endtask

  // stop offering and let every outstanding result arrive
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (alloc_sb.pending() != 0) @(posedge clk);
    repeat (CALC_LAT + 4) @(posedge clk);
  endtask

  // write all eight registers back to back, only while idle
  task automatic write_regs(gain_vec_t gains, gain_t hlim, gain_t vlim);
    reg_idx_t idx;
    gain_t    data;
    for (int r = 0; r < 8; r++) begin
      idx = reg_idx_t'(r);
      case (idx)
        REG_HORIZONTAL_LIMIT: data = hlim;
        REG_VERTICAL_LIMIT:   data = vlim;
        default:              data = gains[r];
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      alloc_sb.write_reg(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      alloc_sb.check_result(out_kind, out_channel, out_amount, out_last);
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    gain_vec_t gv;
    alloc_sb = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_SAMPLE;
    in_surge_axis <= '0;
    in_sway_axis  <= '0;
    in_heave_axis <= '0;
    in_roll_axis  <= '0;
    in_pitch_axis <= '0;
    in_yaw_axis   <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero commands, full scale, most negative roll, band edges
    send_tick();
    send_sample(mk_axes(32767, 32767, 32767, 32767, 32767, 32767));
    send_tick();
    send_sample(mk_axes(-32768, -32768, -32768, -32768, -32768, -32768));
    send_tick();
    send_sample(mk_axes(3276, -3276, 3277, -3277, 3276, -3277));
    send_tick();
    send_tick();
    wait_idle();

    // full-scale gains and limits: thrust saturation both ways
    gv = '1;
    write_regs(gv, 16'hffff, 16'hffff);
    send_sample(mk_axes(32767, 32767, 32767, -32768, -32768, 32767));
    send_tick();
    send_sample(mk_axes(-32768, -32768, -32768, 32767, 32767, -32768));
    send_tick();
    wait_idle();

    // zero gains and limits, then forces with zero limits
    gv = '0;
    write_regs(gv, 16'd0, 16'd0);
    send_sample(rand_axes());
    send_tick();
    wait_idle();
    gv = '1;
    write_regs(gv, 16'd0, 16'd0);
    send_tick();
    wait_idle();

    // random phases, each with its own register settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        gv[a] = rand_reg();
      end
      write_regs(gv, rand_reg(), rand_reg());
      if (ph == RAND_PHASES - 1) begin
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
      end
      if (ph == 2) begin
        hold_rx = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) begin
          wait_idle();
        end
        if ($urandom_range(0, 9) < 3) begin
          send_tick();
        end else begin
          send_sample(rand_axes());
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (alloc_sb.errors == 0 && alloc_sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
